>>> rtl/ttk_pkg.sv
// Shared types, constants and the character map of the keystroke typer.
package ttk_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int TICKS_W     = 20;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [TICKS_W-1:0] HOLD_RESET = 20'd20000;
    localparam logic [TICKS_W-1:0] GAP_RESET  = 20'd20000;
    localparam logic [7:0]         SHIFT_MOD  = 8'h02;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_PRESS   = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_PRESS_HOLD  = 1'b0,
        REG_RELEASE_GAP = 1'b1
    } reg_sel_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_REPORT = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic       shift;
        logic [5:0] usage;
    } key_entry_t;

    typedef struct packed {
        logic       mapped;
        key_entry_t key;
    } key_map_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic last_one;
    } fifo_status_t;

    typedef struct packed {
        logic press;
        logic rel;
        logic held;
    } pace_t;

    typedef struct packed {
        logic [TICKS_W-1:0] press_hold;
        logic [TICKS_W-1:0] release_gap;
    } timing_cfg_t;

    // ASCII byte to HID usage code; shifted characters set the shift flag.
    function automatic key_map_t map_char(logic [7:0] ch);
        key_map_t   m;
        logic [7:0] u;
        m = '0;
        u = 8'h00;
        case (ch) inside
            [8'h61:8'h7A]: u = 8'h04 + (ch - 8'h61);
            [8'h41:8'h5A]: begin u = 8'h04 + (ch - 8'h41); m.key.shift = 1'b1; end
            [8'h31:8'h39]: u = 8'h1E + (ch - 8'h31);
            8'h30: u = 8'h27;
            8'h20: u = 8'h2C;
            8'h0A: u = 8'h28;
            8'h2D: u = 8'h2D;
            8'h3D: u = 8'h2E;
            8'h5B: u = 8'h2F;
            8'h5D: u = 8'h30;
            8'h5C: u = 8'h31;
            8'h3B: u = 8'h33;
            8'h27: u = 8'h34;
            8'h60: u = 8'h35;
            8'h2C: u = 8'h36;
            8'h2E: u = 8'h37;
            8'h2F: u = 8'h38;
            8'h21: begin u = 8'h1E; m.key.shift = 1'b1; end
            8'h40: begin u = 8'h1F; m.key.shift = 1'b1; end
            8'h23: begin u = 8'h20; m.key.shift = 1'b1; end
            8'h24: begin u = 8'h21; m.key.shift = 1'b1; end
            8'h25: begin u = 8'h22; m.key.shift = 1'b1; end
            8'h5E: begin u = 8'h23; m.key.shift = 1'b1; end
            8'h26: begin u = 8'h24; m.key.shift = 1'b1; end
            8'h2A: begin u = 8'h25; m.key.shift = 1'b1; end
            8'h28: begin u = 8'h26; m.key.shift = 1'b1; end
            8'h29: begin u = 8'h27; m.key.shift = 1'b1; end
            8'h5F: begin u = 8'h2D; m.key.shift = 1'b1; end
            8'h2B: begin u = 8'h2E; m.key.shift = 1'b1; end
            8'h7B: begin u = 8'h2F; m.key.shift = 1'b1; end
            8'h7D: begin u = 8'h30; m.key.shift = 1'b1; end
            8'h7C: begin u = 8'h31; m.key.shift = 1'b1; end
            8'h3A: begin u = 8'h33; m.key.shift = 1'b1; end
            8'h22: begin u = 8'h34; m.key.shift = 1'b1; end
            8'h7E: begin u = 8'h35; m.key.shift = 1'b1; end
            8'h3C: begin u = 8'h36; m.key.shift = 1'b1; end
            8'h3E: begin u = 8'h37; m.key.shift = 1'b1; end
            8'h3F: begin u = 8'h38; m.key.shift = 1'b1; end
            default: u = 8'h00;
        endcase
        m.key.usage = u[5:0];
        m.mapped    = (u != 8'h00);
        return m;
    endfunction

endpackage

>>> rtl/ttk_intf.sv
// Valid/ready channel interfaces for command words and result words.
interface ttk_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] character;
    logic [7:0] modifier_bits;
    logic [7:0] key_code;
    logic       link_connected;

    modport source (output valid, command, character, modifier_bits, key_code,
                    link_connected, input ready);
    modport sink   (input valid, command, character, modifier_bits, key_code,
                    link_connected, output ready);
endinterface

interface ttk_res_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic       char_mapped;
    logic       char_stored;
    logic [7:0] report_modifiers;
    logic [7:0] report_keycode;
    logic       queue_empty;

    modport source (output valid, result_kind, char_mapped, char_stored,
                    report_modifiers, report_keycode, queue_empty, input ready);
    modport sink   (input valid, result_kind, char_mapped, char_stored,
                    report_modifiers, report_keycode, queue_empty, output ready);
endinterface

>>> rtl/ttk_cfg_regs.sv
// APB register block holding the press hold and release gap tick counts.
module ttk_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ttk_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ttk_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ttk_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output ttk_pkg::timing_cfg_t             cfg
);
    import ttk_pkg::*;

    logic [TICKS_W-1:0] hold_reg;
    logic [TICKS_W-1:0] gap_reg;
    reg_sel_t           sel;
    logic               wr_en;

    assign pready = 1'b1;
    assign sel    = reg_sel_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= HOLD_RESET;
            gap_reg  <= GAP_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_PRESS_HOLD:  hold_reg <= pwdata[TICKS_W-1:0];
                REG_RELEASE_GAP: gap_reg  <= pwdata[TICKS_W-1:0];
                default:         hold_reg <= hold_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_PRESS_HOLD:  prdata = APB_DATA_W'(hold_reg);
            REG_RELEASE_GAP: prdata = APB_DATA_W'(gap_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.press_hold  = hold_reg;
    assign cfg.release_gap = gap_reg;

endmodule

>>> rtl/ttk_key_fifo.sv
// Circular key queue in a memory with a registered head read.
module ttk_key_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ttk_pkg::key_entry_t   push_key,
    input  logic                  pop,
    output ttk_pkg::key_entry_t   head,
    output ttk_pkg::fifo_status_t status
);
    import ttk_pkg::*;

    key_entry_t       mem [QUEUE_DEPTH];
    key_entry_t       head_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next     = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next     = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        status.empty    = (rd_ptr_reg == wr_ptr_reg);
        status.full     = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);
        status.last_one = (ptr_inc(rd_ptr_reg) == wr_ptr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // The head is re-read every cycle at the next read pointer; a write to that
    // same slot in this cycle is forwarded so the head is never stale.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_key;
        end
        if (push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= push_key;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign head = head_reg;

endmodule

>>> rtl/ttk_pacer.sv
// Tick countdown and held-key flag that pace queued key presses and releases.
module ttk_pacer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic                 fifo_empty,
    input  ttk_pkg::timing_cfg_t cfg,
    output ttk_pkg::pace_t       pace
);
    import ttk_pkg::*;

    logic               held_reg;
    logic               held_next;
    logic [TICKS_W-1:0] wait_reg;
    logic [TICKS_W-1:0] wait_next;
    logic               act;

    always_comb
    begin
        // A count of zero or one reaches zero on this tick, so the tick acts.
        act        = (wait_reg[TICKS_W-1:1] == '0);
        pace.press = tick && act && !held_reg && !fifo_empty;
        pace.rel   = tick && act && held_reg;
        pace.held  = held_reg;
        held_next  = held_reg;
        wait_next  = wait_reg;
        if (tick)
        begin
            if (!act)
            begin
                wait_next = wait_reg - TICKS_W'(1);
            end
            else if (held_reg)
            begin
                held_next = 1'b0;
                wait_next = cfg.release_gap;
            end
            else if (!fifo_empty)
            begin
                held_next = 1'b1;
                wait_next = cfg.press_hold;
            end
            else
            begin
                wait_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            wait_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            wait_reg <= wait_next;
        end
    end

endmodule

>>> rtl/text_to_keystroke_typer.sv
// Top level of the ASCII to HID keystroke typer.
// Throughput: one command word per cycle when the result register is free; the input
// register and the result register form a two-stage pipe that advances on that condition.
// Reset (rst_n low, asynchronous): the queue empties, no key is held, the tick
// countdown is zero and both timing registers return to 20000 ticks.
module text_to_keystroke_typer (
    input  logic                           clk,
    input  logic                           rst_n,
    ttk_cmd_if.sink                        items,
    ttk_res_if.source                      results,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ttk_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ttk_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ttk_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ttk_pkg::*;

    // Input register: the accepted command word waits here while the queue head
    // for the current read pointer is fetched from memory.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    cmd_t       s1_cmd_reg;
    logic [7:0] s1_char_reg;
    logic [7:0] s1_mods_reg;
    logic [7:0] s1_key_reg;
    logic       s1_link_reg;

    // Result register.
    logic         out_valid_reg;
    logic         out_valid_next;
    result_kind_t out_kind_reg;
    result_kind_t out_kind_next;
    logic         out_mapped_reg;
    logic         out_mapped_next;
    logic         out_stored_reg;
    logic         out_stored_next;
    logic [7:0]   out_mods_reg;
    logic [7:0]   out_mods_next;
    logic [7:0]   out_keycode_reg;
    logic [7:0]   out_keycode_next;
    logic         out_empty_reg;
    logic         out_empty_next;

    logic         out_free;
    logic         step;
    logic         accept;
    logic         push;
    logic         has_result;
    key_map_t     map;
    key_entry_t   head;
    fifo_status_t fstat;
    pace_t        pace;
    timing_cfg_t  cfg;

    ttk_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The stage holding a word moves on whenever the result register can take
    // its outcome, whether or not that word produces a result.
    assign out_free    = !out_valid_reg || results.ready;
    assign step        = s1_valid_reg && out_free;
    assign items.ready = !s1_valid_reg || out_free;
    assign accept      = items.valid && items.ready;

    assign map  = map_char(s1_char_reg);
    assign push = step && (s1_cmd_reg == CMD_ENQUEUE) && map.mapped && !fstat.full;

    ttk_key_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_key (map.key),
        .pop      (pace.press),
        .head     (head),
        .status   (fstat)
    );

    ttk_pacer u_pacer (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (step && (s1_cmd_reg == CMD_TICK)),
        .fifo_empty (fstat.empty),
        .cfg        (cfg),
        .pace       (pace)
    );

    // Result formation. Enqueue always reports its status; every keyboard report,
    // direct or paced, is dropped while the link is down, but the queue and the
    // pacer state move on regardless.
    always_comb
    begin
        has_result       = 1'b0;
        out_kind_next    = KIND_REPORT;
        out_mapped_next  = 1'b0;
        out_stored_next  = 1'b0;
        out_mods_next    = 8'h00;
        out_keycode_next = 8'h00;
        out_empty_next   = fstat.empty;
        case (s1_cmd_reg)
            CMD_ENQUEUE:
            begin
                has_result      = 1'b1;
                out_kind_next   = KIND_STATUS;
                out_mapped_next = map.mapped;
                out_stored_next = push;
                out_empty_next  = fstat.empty && !push;
            end
            CMD_TICK:
            begin
                if (pace.rel)
                begin
                    has_result = s1_link_reg;
                end
                else if (pace.press)
                begin
                    has_result       = s1_link_reg;
                    out_mods_next    = head.shift ? SHIFT_MOD : 8'h00;
                    out_keycode_next = {2'b00, head.usage};
                    out_empty_next   = fstat.last_one;
                end
            end
            CMD_PRESS:
            begin
                has_result       = s1_link_reg;
                out_mods_next    = s1_mods_reg;
                out_keycode_next = s1_key_reg;
            end
            CMD_RELEASE:
            begin
                has_result = s1_link_reg;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = has_result;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= cmd_t'(items.command);
            s1_char_reg <= items.character;
            s1_mods_reg <= items.modifier_bits;
            s1_key_reg  <= items.key_code;
            s1_link_reg <= items.link_connected;
        end
        if (step && has_result)
        begin
            out_kind_reg    <= out_kind_next;
            out_mapped_reg  <= out_mapped_next;
            out_stored_reg  <= out_stored_next;
            out_mods_reg    <= out_mods_next;
            out_keycode_reg <= out_keycode_next;
            out_empty_reg   <= out_empty_next;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.result_kind      = out_kind_reg;
    assign results.char_mapped      = out_mapped_reg;
    assign results.char_stored      = out_stored_reg;
    assign results.report_modifiers = out_mods_reg;
    assign results.report_keycode   = out_keycode_reg;
    assign results.queue_empty      = out_empty_reg;

    // A paced press leaves a key held on the next cycle.
    a_press_sets_held: assert property (@(posedge clk) disable iff (!rst_n)
        pace.press |=> pace.held)
        else $error("key not held after a paced press");

    // A paced release clears the held flag on the next cycle.
    a_release_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        pace.rel |=> !pace.held)
        else $error("key still held after a paced release");

    // The command side only stalls when both pipeline registers are occupied.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !items.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("command side stalled with a free stage");

    // A key just stored cannot leave the queue reported as empty.
    a_stored_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (step && push) |=> (out_valid_reg && !out_empty_reg))
        else $error("stored key reported with an empty queue");

endmodule
